@@ hdl/reversible_list_store_defines.svh @@
// Assertion macros shared by the reversible list store RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef REVERSIBLE_LIST_STORE_DEFINES_SVH
`define REVERSIBLE_LIST_STORE_DEFINES_SVH

// Implication checked on every rising edge, held off while reset is asserted.
`define RLS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Condition that must never be seen on a rising edge outside reset.
`define RLS_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

@@ hdl/rls_pkg.sv @@
// Types shared by the reversible list store controller, datapath and top level.
// Depends on nothing.
package rls_pkg;

    typedef enum logic [1:0] {
        REQ_INSERT  = 2'd0,
        REQ_DELETE  = 2'd1,
        REQ_VIEW    = 2'd2,
        REQ_REVERSE = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Commands from the controller to the datapath, given anew in each cycle.
    typedef struct packed {
        logic    insert;
        logic    delete;
        logic    flip;
        logic    read;
        logic    emit;
        logic    last;
        t_status status;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic empty;
        logic full;
        logic at_last;
    } t_stat;

endpackage

@@ hdl/rls_dp.sv @@
// Datapath of the reversible list store: ring memory, base slot, fill count,
// order flag and result registers. Depends on rls_pkg.
module rls_dp #(
    parameter int DEPTH = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  rls_pkg::t_cmd                i_cmd,
    input  logic [$clog2(DEPTH)-1:0]     i_idx,
    input  logic signed [31:0]           i_value,
    output rls_pkg::t_stat               o_stat,
    output logic                         o_valid,
    output logic [1:0]                   o_status,
    output logic signed [31:0]           o_element,
    output logic                         o_last
);
    import rls_pkg::*;

    localparam int SW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [SW:0]   DEPTH_X  = (SW + 1)'(DEPTH);
    localparam logic [SW-1:0] TOP_SLOT = SW'(DEPTH - 1);

    logic signed [31:0] r_mem [DEPTH];

    logic [SW-1:0] r_base, n_base;
    logic [CW-1:0] r_count, n_count;
    logic          r_flag, n_flag;

    logic               r_valid;
    logic [1:0]         r_status;
    logic               r_last;
    logic               r_elem_sel;
    logic signed [31:0] r_rd_data;

    logic [CW-1:0] cnt_m1;
    logic [SW-1:0] off;
    logic [SW-1:0] rd_slot;
    logic [SW-1:0] wr_slot;
    logic [SW-1:0] base_dec;
    logic [SW-1:0] base_inc;

    // Ring addition; both operands are below DEPTH, so one subtract suffices.
    function automatic logic [SW-1:0] ring_add(input logic [SW-1:0] a,
                                               input logic [SW-1:0] b);
        logic [SW:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= DEPTH_X) begin
            sum = sum - DEPTH_X;
        end
        return sum[SW-1:0];
    endfunction

    always_comb begin
        n_flag   = r_flag ^ i_cmd.flip;
        cnt_m1   = r_count - CW'(1);
        off      = n_flag ? SW'(cnt_m1 - CW'(i_idx)) : i_idx;
        rd_slot  = ring_add(r_base, off);
        base_dec = (r_base == '0) ? TOP_SLOT : r_base - SW'(1);
        base_inc = (r_base == TOP_SLOT) ? '0 : r_base + SW'(1);
        wr_slot  = r_flag ? base_dec : ring_add(r_base, SW'(r_count));

        n_base  = r_base;
        n_count = r_count;
        if (i_cmd.insert) begin
            n_count = r_count + CW'(1);
            if (r_flag) begin
                n_base = base_dec;
            end
        end else if (i_cmd.delete) begin
            n_count = r_count - CW'(1);
            if (r_flag) begin
                n_base = base_inc;
            end
        end
    end

    assign o_stat.empty   = (r_count == '0);
    assign o_stat.full    = (r_count == CW'(DEPTH));
    assign o_stat.at_last = (cnt_m1 == CW'(i_idx));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= '0;
            r_count <= '0;
            r_flag  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_base  <= n_base;
            r_count <= n_count;
            r_flag  <= n_flag;
            r_valid <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_status   <= i_cmd.status;
            r_last     <= i_cmd.last;
            r_elem_sel <= i_cmd.read;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.insert) begin
            r_mem[wr_slot] <= i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_rd_data <= r_mem[rd_slot];
        end
    end

    assign o_valid   = r_valid;
    assign o_status  = r_status;
    assign o_last    = r_last;
    assign o_element = r_elem_sel ? r_rd_data : '0;

endmodule

@@ hdl/rls_ctrl.sv @@
// Controller of the reversible list store: decodes requests and sequences
// the element stream of a view. Depends on rls_pkg.
module rls_ctrl #(
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [1:0]               i_req_type,
    input  rls_pkg::t_stat           i_stat,
    output rls_pkg::t_cmd            o_cmd,
    output logic [$clog2(DEPTH)-1:0] o_idx,
    output logic                     o_busy
);
    import rls_pkg::*;

    localparam int SW = $clog2(DEPTH);

    typedef enum logic {
        S_IDLE,
        S_VIEW
    } t_state;

    t_state        r_state;
    logic [SW-1:0] r_idx;
    logic          accept;
    t_req          req;

    assign accept = i_start && (r_state == S_IDLE);
    assign req    = t_req'(i_req_type);
    assign o_idx  = (r_state == S_IDLE) ? '0 : r_idx;
    assign o_busy = (r_state == S_VIEW);

    always_comb begin
        o_cmd = '{insert: 1'b0, delete: 1'b0, flip: 1'b0, read: 1'b0,
                  emit: 1'b0, last: 1'b0, status: ST_OK};
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.last = 1'b1;
                    unique case (req)
                        REQ_INSERT: begin
                            o_cmd.insert = !i_stat.full;
                            o_cmd.status = i_stat.full ? ST_FULL : ST_OK;
                        end
                        REQ_DELETE: begin
                            o_cmd.delete = !i_stat.empty;
                            o_cmd.status = i_stat.empty ? ST_EMPTY : ST_OK;
                        end
                        REQ_VIEW, REQ_REVERSE: begin
                            o_cmd.flip = (req == REQ_REVERSE);
                            if (i_stat.empty) begin
                                o_cmd.status = ST_EMPTY;
                            end else begin
                                o_cmd.read = 1'b1;
                                o_cmd.last = i_stat.at_last;
                            end
                        end
                    endcase
                end
            end
            S_VIEW: begin
                o_cmd.read = 1'b1;
                o_cmd.emit = 1'b1;
                o_cmd.last = i_stat.at_last;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (o_cmd.read && !i_stat.at_last) begin
                        r_state <= S_VIEW;
                        r_idx   <= SW'(1);
                    end
                end
                S_VIEW: begin
                    if (i_stat.at_last) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_idx <= r_idx + SW'(1);
                    end
                end
            endcase
        end
    end

endmodule

@@ hdl/reversible_list_store.sv @@
// Reversible list store: a bounded list of signed 32-bit values in a ring
// memory of DEPTH slots. A request (i_req_type, i_value) is taken at a rising
// edge where i_start is high and o_busy is low. Request kinds are insert at
// the logical end, delete the logical end, view front to back, and reverse
// followed by a view.
// Every result appears on o_status, o_element and o_last for exactly one
// cycle, marked by o_valid, starting in the cycle after the request is taken.
// The receiver has no way to hold results off, and needs none.
// Insert, delete and a view of an empty list give one result and leave
// o_busy low, so a new request may follow in every cycle. A view of N
// elements streams one element per cycle; o_busy is high after acceptance
// until the last element is read, as the single memory read port is used
// once per element. o_last marks the final result of each request.
// Reverse only toggles an order flag, so it costs nothing beyond its view.
// Reset (i_rst_n low at a rising edge) empties the list and clears the flag;
// the memory itself is not cleared, as only written slots are ever read.
// Depends on rls_pkg, rls_ctrl, rls_dp and reversible_list_store_defines.svh.
`include "reversible_list_store_defines.svh"

module reversible_list_store #(
    parameter int DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic [1:0]         i_req_type,
    input  logic signed [31:0] i_value,
    output logic               o_valid,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_element,
    output logic               o_last
);
    import rls_pkg::*;

    localparam int SW = $clog2(DEPTH);

    t_cmd          cmd;
    t_stat         stat;
    logic [SW-1:0] idx;

    // The controller decides what each cycle does; the datapath holds the
    // list state, the ring memory and the result registers.
    rls_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .i_req_type (i_req_type),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_idx      (idx),
        .o_busy     (o_busy)
    );

    rls_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_idx     (idx),
        .i_value   (i_value),
        .o_stat    (stat),
        .o_valid   (o_valid),
        .o_status  (o_status),
        .o_element (o_element),
        .o_last    (o_last)
    );

    // While a view is streaming, every cycle must produce a result.
    `RLS_ASSERT(a_busy_streams, o_busy |=> o_valid, "view stream stalled")
    // A result that is not the last of its request leaves the block busy.
    `RLS_ASSERT(a_more_busy, (o_valid && !o_last) |-> o_busy, "stream ended early")
    // Only ok results can be followed by more results of the same request.
    `RLS_ASSERT(a_mid_ok, (o_valid && !o_last) |-> (o_status == ST_OK),
                "error status inside a stream")
    // An error result is single and carries no element.
    `RLS_ASSERT(a_err_single,
                (o_valid && (o_status != ST_OK)) |-> (o_last && (o_element == '0)),
                "malformed error result")

endmodule

@@ tb/list_store_check_pkg.sv @@
// Scoreboard for the reversible list store: a bit-true copy of the ring list
// and a queue of the results it predicts. Depends on rls_pkg.
`timescale 1ns / 1ps

package list_store_check_pkg;
    import rls_pkg::*;

    localparam int LIST_DEPTH   = 64;
    localparam int REPORT_LIMIT = 10;

    typedef struct {
        logic [1:0]  status;
        logic [31:0] element;
        logic        last;
    } t_list_result;

    class t_list_store_scoreboard;
        logic [31:0]  slots [LIST_DEPTH];
        logic [5:0]   base_slot;
        int unsigned  fill;
        bit           flipped;
        t_list_result awaited_results [$];
        int unsigned  mismatches;
        int unsigned  results_seen;
        int unsigned  requests_seen;
        int unsigned  peak_fill;
        int unsigned  full_drops;
        int unsigned  empty_hits;

        function new();
            base_slot     = '0;
            fill          = 0;
            flipped       = 0;
            mismatches    = 0;
            results_seen  = 0;
            requests_seen = 0;
            peak_fill     = 0;
            full_drops    = 0;
            empty_hits    = 0;
        endfunction

        function void push_result(t_status status, logic [31:0] element, logic last);
            t_list_result r;
            r.status  = status;
            r.element = element;
            r.last    = last;
            awaited_results.push_back(r);
        endfunction

        // Front-to-back walk; the flag decides which end of the run is the front.
        function void stream_view();
            int unsigned off;
            if (fill == 0) begin
                empty_hits++;
                push_result(ST_EMPTY, '0, 1'b1);
            end else begin
                for (int unsigned i = 0; i < fill; i++) begin
                    off = flipped ? (fill - 1 - i) : i;
                    push_result(ST_OK, slots[6'(base_slot + off)], (i + 1 == fill));
                end
            end
        endfunction

        function void note_request(logic [1:0] kind, logic [31:0] value);
            requests_seen++;
            case (t_req'(kind))
                REQ_INSERT: begin
                    if (fill >= LIST_DEPTH) begin
                        full_drops++;
                        push_result(ST_FULL, '0, 1'b1);
                    end else begin
                        if (flipped) begin
                            base_slot        = base_slot - 6'd1;
                            slots[base_slot] = value;
                        end else begin
                            slots[6'(base_slot + fill)] = value;
                        end
                        fill++;
                        if (fill > peak_fill) peak_fill = fill;
                        push_result(ST_OK, '0, 1'b1);
                    end
                end
                REQ_DELETE: begin
                    if (fill == 0) begin
                        empty_hits++;
                        push_result(ST_EMPTY, '0, 1'b1);
                    end else begin
                        if (flipped) base_slot = base_slot + 6'd1;
                        fill--;
                        push_result(ST_OK, '0, 1'b1);
                    end
                end
                REQ_VIEW: begin
                    stream_view();
                end
                default: begin
                    flipped = !flipped;
                    stream_view();
                end
            endcase
        endfunction

        function void check_result(logic [1:0] status, logic [31:0] element, logic last);
            t_list_result want;
            results_seen++;
            if (awaited_results.size() == 0) begin
                if (mismatches < REPORT_LIMIT)
                    $display("ERROR: unexpected result status=%0d element=%h last=%b",
                             status, element, last);
                mismatches++;
                return;
            end
            want = awaited_results.pop_front();
            if (status !== want.status || element !== want.element || last !== want.last) begin
                if (mismatches < REPORT_LIMIT)
                    $display({"ERROR: result mismatch: expected status=%0d element=%h ",
                              "last=%b, got status=%0d element=%h last=%b"},
                             want.status, want.element, want.last, status, element, last);
                mismatches++;
            end
        endfunction

        function int unsigned pending();
            return awaited_results.size();
        endfunction
    endclass

endpackage

@@ tb/tb_top.sv @@
// Top-level testbench for reversible_list_store: drives insert, delete, view
// and reverse requests and checks every result. Depends on rls_pkg and list_store_check_pkg.
`timescale 1ns / 1ps

module tb_top;
    import rls_pkg::*;
    import list_store_check_pkg::*;

    // Cycles with neither an accepted request nor a result before the run is
    // declared hung.
    localparam int WATCHDOG_LIMIT = 1000;
    // Results start in the cycle after acceptance; a short drain at the end
    // catches any stray result that arrives once nothing is expected.
    localparam int DRAIN_CYCLES   = 16;
    localparam int RANDOM_ITEMS   = 330;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_start;
    logic               o_busy;
    logic [1:0]         i_req_type;
    logic signed [31:0] i_value;
    logic               o_valid;
    logic [1:0]         o_status;
    logic signed [31:0] o_element;
    logic               o_last;

    t_list_store_scoreboard sb;
    int unsigned            idle_cycles;
    bit                     no_idle;

    reversible_list_store #(.DEPTH(LIST_DEPTH)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .o_busy     (o_busy),
        .i_req_type (i_req_type),
        .i_value    (i_value),
        .o_valid    (o_valid),
        .o_status   (o_status),
        .o_element  (o_element),
        .o_last     (o_last)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Monitor. Everything is sampled at the rising edge, where the inputs have
    // been stable since the falling edge and the outputs still hold the values
    // of the cycle that is ending. A result is checked before a request taken
    // at the same edge is noted; the queue order would be the same either way,
    // since the new request's results can only start in the next cycle.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid)
                sb.check_result(o_status, o_element, o_last);
            if (i_start && !o_busy)
                sb.note_request(i_req_type, i_value);
            if (o_valid || (i_start && !o_busy))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("ERROR: no progress for %0d cycles", WATCHDOG_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Gap before the next request. Some phases run with no idling at all so
    // that requests follow back to back, including straight after a stream.
    function automatic int unsigned draw_gap();
        return no_idle ? 0 : $urandom_range(0, 19);
    endfunction

    // Mostly fully random words; now and then one of the extreme values.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 15))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Called at a falling edge once the previous request has been taken. With
    // no gap, start stays high and only the fields change, so start never sees
    // two assignments in one step. Returns at a falling edge once the request is taken and o_busy is low.
    task automatic issue_request(t_req kind, logic [31:0] value, int unsigned gap);
        if (gap > 0) begin
            i_start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_start    = 1'b1;
        i_req_type = kind;
        i_value    = value;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    initial begin
        int unsigned phase_no;
        int unsigned phase_len;
        int unsigned phase_kind;
        int unsigned sent;
        int unsigned roll;
        t_req        kind;

        sb          = new();
        idle_cycles = 0;
        no_idle     = 1'b0;
        i_rst_n     = 1'b0;
        i_start     = 1'b0;
        i_req_type  = REQ_INSERT;
        i_value     = '0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part. Empty-list cases first: view, delete and a reverse
        // that still toggles the order flag even though nothing is stored.
        issue_request(REQ_VIEW,    $urandom, draw_gap());
        issue_request(REQ_DELETE,  $urandom, draw_gap());
        issue_request(REQ_REVERSE, $urandom, draw_gap());
        // The flag is now set, so these inserts grow the list downwards from
        // the base slot and wrap it below zero.
        issue_request(REQ_INSERT,  32'h8000_0000, draw_gap());
        issue_request(REQ_INSERT,  32'h7FFF_FFFF, draw_gap());
        issue_request(REQ_VIEW,    $urandom, draw_gap());
        issue_request(REQ_REVERSE, $urandom, draw_gap());
        issue_request(REQ_INSERT,  32'h0000_0000, draw_gap());
        issue_request(REQ_INSERT,  32'hFFFF_FFFF, draw_gap());
        issue_request(REQ_INSERT,  32'h5555_5555, draw_gap());
        issue_request(REQ_INSERT,  32'hAAAA_AAAA, draw_gap());
        issue_request(REQ_VIEW,    $urandom, draw_gap());
        // Reversed again: deletes now drop the old front, inserts add before it.
        issue_request(REQ_REVERSE, $urandom, draw_gap());
        issue_request(REQ_DELETE,  $urandom, draw_gap());
        issue_request(REQ_INSERT,  32'h1234_5678, draw_gap());
        issue_request(REQ_VIEW,    $urandom, draw_gap());
        issue_request(REQ_REVERSE, $urandom, draw_gap());
        // Drain past empty so that a delete on an empty list is seen twice.
        repeat (8) issue_request(REQ_DELETE, $urandom, draw_gap());
        issue_request(REQ_VIEW,    $urandom, draw_gap());

        // Random part in phases: growing phases push the list to full and
        // beyond, shrinking phases pull it back to empty, mixed phases stir
        // the order flag and stream long views in between.
        sent     = 0;
        phase_no = 0;
        while (sent < RANDOM_ITEMS) begin
            phase_kind = phase_no % 4;
            phase_len  = (phase_kind == 1 || phase_kind == 3) ? $urandom_range(30, 80)
                                                               : $urandom_range(70, 100);
            no_idle    = ($urandom_range(0, 3) == 0);
            for (int unsigned k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
                roll = $urandom_range(0, 99);
                case (phase_kind)
                    0: kind = (roll < 85) ? REQ_INSERT : (roll < 88) ? REQ_DELETE :
                              (roll < 94) ? REQ_VIEW   : REQ_REVERSE;
                    2: kind = (roll < 80) ? REQ_DELETE : (roll < 86) ? REQ_INSERT :
                              (roll < 93) ? REQ_VIEW   : REQ_REVERSE;
                    default:
                       kind = (roll < 35) ? REQ_INSERT : (roll < 65) ? REQ_DELETE :
                              (roll < 85) ? REQ_VIEW   : REQ_REVERSE;
                endcase
                issue_request(kind, pick_value(), draw_gap());
                sent++;
            end
            phase_no++;
        end
        i_start = 1'b0;

        // Wait for every predicted result, then a little longer for strays.
        // The watchdog ends the run if the block stops producing.
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d requests and %0d results; list peaked at %0d entries.",
                 sb.requests_seen, sb.results_seen, sb.peak_fill);
        $display("Inserts dropped on a full list: %0d; empty-list results: %0d; %s%0d.",
                 sb.full_drops, sb.empty_hits, "mismatches: ", sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
